// File: rtl/rgb_to_hsv_converter_defines.svh
// Assertion macros for the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define RHC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_converter: same-cycle check failed");

// Next-cycle implication, reset-qualified.
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rgb_to_hsv_converter: next-cycle check failed");

`endif

// File: rtl/rgbhsv_pkg.sv
// Shared constants and types for the RGB to HSV converter.
`timescale 1ns / 1ps

package rgbhsv_pkg;

    localparam int CHANNEL_BITS_DEF = 8;
    localparam int FRAC_BITS_DEF    = 8;

    localparam int BASE_BITS = 3;

    // Hexcone sector base, picked by the minimum channel.
    localparam logic [BASE_BITS-1:0] BASE_RED_MIN   = 3'd3;
    localparam logic [BASE_BITS-1:0] BASE_GREEN_MIN = 3'd5;
    localparam logic [BASE_BITS-1:0] BASE_BLUE_MIN  = 3'd1;

    typedef struct packed {
        logic                 gray;
        logic                 neg;
        logic [BASE_BITS-1:0] base;
    } t_ctl;

endpackage

// File: rtl/rgbhsv_front.sv
// Front stage: max/min, sector select, delta and absolute channel difference.
`timescale 1ns / 1ps

module rgbhsv_front #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    output logic                    o_valid,
    output rgbhsv_pkg::t_ctl        o_ctl,
    output logic [CHANNEL_BITS-1:0] o_hi,
    output logic [CHANNEL_BITS-1:0] o_delta,
    output logic [CHANNEL_BITS-1:0] o_adiff
);

    logic [CHANNEL_BITS-1:0] n_hi, n_lo, n_delta, n_adiff, w_x, w_y;
    rgbhsv_pkg::t_ctl        n_ctl;

    logic                    r_valid;
    rgbhsv_pkg::t_ctl        r_ctl;
    logic [CHANNEL_BITS-1:0] r_hi, r_delta, r_adiff;

    always_comb begin
        n_hi = i_red;
        if (i_green > n_hi) n_hi = i_green;
        if (i_blue > n_hi) n_hi = i_blue;
        n_lo = i_red;
        if (i_green < n_lo) n_lo = i_green;
        if (i_blue < n_lo) n_lo = i_blue;

        if (i_red == n_lo) begin
            n_ctl.base = rgbhsv_pkg::BASE_RED_MIN;
            w_x        = i_green;
            w_y        = i_blue;
        end else if (i_green == n_lo) begin
            n_ctl.base = rgbhsv_pkg::BASE_GREEN_MIN;
            w_x        = i_blue;
            w_y        = i_red;
        end else begin
            n_ctl.base = rgbhsv_pkg::BASE_BLUE_MIN;
            w_x        = i_red;
            w_y        = i_green;
        end
        n_ctl.neg  = (w_x < w_y);
        n_ctl.gray = (n_hi == n_lo);
        n_adiff    = n_ctl.neg ? (w_y - w_x) : (w_x - w_y);
        n_delta    = n_hi - n_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl   <= n_ctl;
            r_hi    <= n_hi;
            r_delta <= n_delta;
            r_adiff <= n_adiff;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_hi    = r_hi;
    assign o_delta = r_delta;
    assign o_adiff = r_adiff;

endmodule

// File: rtl/rgbhsv_div_stage.sv
// One restoring-division step for both the hue and saturation quotients.
`timescale 1ns / 1ps

module rgbhsv_div_stage #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF,
    parameter int FRAC_BITS    = rgbhsv_pkg::FRAC_BITS_DEF,
    parameter bit FIRST        = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  rgbhsv_pkg::t_ctl        i_ctl,
    input  logic [CHANNEL_BITS:0]   i_h_rem,
    input  logic [CHANNEL_BITS-1:0] i_h_div,
    input  logic [FRAC_BITS:0]      i_h_quo,
    input  logic [CHANNEL_BITS:0]   i_s_rem,
    input  logic [CHANNEL_BITS-1:0] i_s_div,
    input  logic [FRAC_BITS:0]      i_s_quo,
    output logic                    o_valid,
    output rgbhsv_pkg::t_ctl        o_ctl,
    output logic [CHANNEL_BITS:0]   o_h_rem,
    output logic [CHANNEL_BITS-1:0] o_h_div,
    output logic [FRAC_BITS:0]      o_h_quo,
    output logic [CHANNEL_BITS:0]   o_s_rem,
    output logic [CHANNEL_BITS-1:0] o_s_div,
    output logic [FRAC_BITS:0]      o_s_quo
);

    logic [CHANNEL_BITS:0]   w_h_cand, w_s_cand, n_h_rem, n_s_rem;
    logic                    w_h_ge, w_s_ge;

    logic                    r_valid;
    rgbhsv_pkg::t_ctl        r_ctl;
    logic [CHANNEL_BITS:0]   r_h_rem, r_s_rem;
    logic [CHANNEL_BITS-1:0] r_h_div, r_s_div;
    logic [FRAC_BITS:0]      r_h_quo, r_s_quo;

    always_comb begin
        w_h_cand = FIRST ? i_h_rem : {i_h_rem[CHANNEL_BITS-1:0], 1'b0};
        w_s_cand = FIRST ? i_s_rem : {i_s_rem[CHANNEL_BITS-1:0], 1'b0};
        w_h_ge   = (w_h_cand >= {1'b0, i_h_div});
        w_s_ge   = (w_s_cand >= {1'b0, i_s_div});
        n_h_rem  = w_h_ge ? (w_h_cand - {1'b0, i_h_div}) : w_h_cand;
        n_s_rem  = w_s_ge ? (w_s_cand - {1'b0, i_s_div}) : w_s_cand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl   <= i_ctl;
            r_h_rem <= n_h_rem;
            r_s_rem <= n_s_rem;
            r_h_div <= i_h_div;
            r_s_div <= i_s_div;
            r_h_quo <= {i_h_quo[FRAC_BITS-1:0], w_h_ge};
            r_s_quo <= {i_s_quo[FRAC_BITS-1:0], w_s_ge};
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_h_rem = r_h_rem;
    assign o_s_rem = r_s_rem;
    assign o_h_div = r_h_div;
    assign o_s_div = r_s_div;
    assign o_h_quo = r_h_quo;
    assign o_s_quo = r_s_quo;

endmodule

// File: rtl/rgbhsv_back.sv
// Output stage: hue assembly from sector base and quotient, gray masking.
`timescale 1ns / 1ps

module rgbhsv_back #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF,
    parameter int FRAC_BITS    = rgbhsv_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  rgbhsv_pkg::t_ctl        i_ctl,
    input  logic [CHANNEL_BITS-1:0] i_hi,
    input  logic [FRAC_BITS:0]      i_h_quo,
    input  logic [FRAC_BITS:0]      i_s_quo,
    output logic                    o_valid,
    output logic [FRAC_BITS+2:0]    o_hue,
    output logic [FRAC_BITS:0]      o_saturation,
    output logic [CHANNEL_BITS-1:0] o_brightness,
    output logic                    o_hue_undefined
);

    localparam int HUE_BITS = FRAC_BITS + 3;

    logic [HUE_BITS-1:0]     w_base_sc, w_quo, n_hue;
    logic [FRAC_BITS:0]      n_sat;

    logic                    r_valid;
    logic [HUE_BITS-1:0]     r_hue;
    logic [FRAC_BITS:0]      r_sat;
    logic [CHANNEL_BITS-1:0] r_val;
    logic                    r_undef;

    always_comb begin
        w_base_sc = {i_ctl.base, {FRAC_BITS{1'b0}}};
        w_quo     = {2'b00, i_h_quo};
        if (i_ctl.gray) begin
            n_hue = '0;
            n_sat = '0;
        end else begin
            n_hue = i_ctl.neg ? (w_base_sc + w_quo) : (w_base_sc - w_quo);
            n_sat = i_s_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_val   <= i_hi;
            r_undef <= i_ctl.gray;
        end
    end

    assign o_valid         = r_valid;
    assign o_hue           = r_hue;
    assign o_saturation    = r_sat;
    assign o_brightness    = r_val;
    assign o_hue_undefined = r_undef;

endmodule

// File: rtl/rgb_to_hsv_converter.sv
// RGB to hexcone HSV converter, pipelined top level.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  pixel in | input     | i_valid / o_stall    | i_red, i_green, i_blue
//  hsv out  | output    | o_valid / i_stall    | o_hue, o_saturation, o_brightness,
//           |           |                      | o_hue_undefined
//
// One request per clock while o_stall is low.
// The two restoring dividers run side by side, one quotient bit per stage.
// Each stage holds only while it is full and the stage after it is held,
// so bubbles close up and a stalled output still lets earlier stages fill.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF,
    parameter int FRAC_BITS    = rgbhsv_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [FRAC_BITS+2:0]    o_hue,
    output logic [FRAC_BITS:0]      o_saturation,
    output logic [CHANNEL_BITS-1:0] o_brightness,
    output logic                    o_hue_undefined
);

    localparam int NSTEP = FRAC_BITS + 1;

    logic                    w_valid [0:NSTEP];
    rgbhsv_pkg::t_ctl        w_ctl   [0:NSTEP];
    logic [CHANNEL_BITS:0]   w_h_rem [0:NSTEP];
    logic [CHANNEL_BITS-1:0] w_h_div [0:NSTEP];
    logic [FRAC_BITS:0]      w_h_quo [0:NSTEP];
    logic [CHANNEL_BITS:0]   w_s_rem [0:NSTEP];
    logic [CHANNEL_BITS-1:0] w_s_div [0:NSTEP];
    logic [FRAC_BITS:0]      w_s_quo [0:NSTEP];
    logic                    w_adv   [0:NSTEP+1];
    logic [CHANNEL_BITS-1:0] w_delta, w_adiff;

    assign w_adv[NSTEP+1] = !o_valid || !i_stall;

    genvar k;
    generate
        for (k = 0; k <= NSTEP; k++) begin : g_adv
            assign w_adv[k] = !w_valid[k] || w_adv[k+1];
        end
    endgenerate

    assign o_stall = !w_adv[0];

    rgbhsv_front #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv[0]),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (w_valid[0]),
        .o_ctl   (w_ctl[0]),
        .o_hi    (w_s_div[0]),
        .o_delta (w_delta),
        .o_adiff (w_adiff)
    );

    assign w_h_rem[0] = {1'b0, w_adiff};
    assign w_h_div[0] = w_delta;
    assign w_s_rem[0] = {1'b0, w_delta};
    assign w_h_quo[0] = '0;
    assign w_s_quo[0] = '0;

    generate
        for (k = 0; k < NSTEP; k++) begin : g_div
            rgbhsv_div_stage #(
                .CHANNEL_BITS(CHANNEL_BITS),
                .FRAC_BITS   (FRAC_BITS),
                .FIRST       (k == 0)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_adv[k+1]),
                .i_valid (w_valid[k]),
                .i_ctl   (w_ctl[k]),
                .i_h_rem (w_h_rem[k]),
                .i_h_div (w_h_div[k]),
                .i_h_quo (w_h_quo[k]),
                .i_s_rem (w_s_rem[k]),
                .i_s_div (w_s_div[k]),
                .i_s_quo (w_s_quo[k]),
                .o_valid (w_valid[k+1]),
                .o_ctl   (w_ctl[k+1]),
                .o_h_rem (w_h_rem[k+1]),
                .o_h_div (w_h_div[k+1]),
                .o_h_quo (w_h_quo[k+1]),
                .o_s_rem (w_s_rem[k+1]),
                .o_s_div (w_s_div[k+1]),
                .o_s_quo (w_s_quo[k+1])
            );
        end
    endgenerate

    rgbhsv_back #(
        .CHANNEL_BITS(CHANNEL_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_adv[NSTEP+1]),
        .i_valid         (w_valid[NSTEP]),
        .i_ctl           (w_ctl[NSTEP]),
        .i_hi            (w_s_div[NSTEP]),
        .i_h_quo         (w_h_quo[NSTEP]),
        .i_s_quo         (w_s_quo[NSTEP]),
        .o_valid         (o_valid),
        .o_hue           (o_hue),
        .o_saturation    (o_saturation),
        .o_brightness    (o_brightness),
        .o_hue_undefined (o_hue_undefined)
    );

    `RHC_ASSERT_NOW(a_gray_zero, i_clk, i_rst_n, o_valid && o_hue_undefined, (o_hue == '0) && (o_saturation == '0))
    `RHC_ASSERT_NOW(a_color_sat, i_clk, i_rst_n, o_valid && !o_hue_undefined, (o_saturation != '0) && (o_brightness != '0))
    `RHC_ASSERT_NOW(a_hue_range, i_clk, i_rst_n, o_valid && !o_hue_undefined, o_hue <= {3'd6, {FRAC_BITS{1'b0}}})
    `RHC_ASSERT_NEXT(a_out_ready_pulls, i_clk, i_rst_n, o_valid && !i_stall && !w_valid[NSTEP], !o_valid)

endmodule
